// ===== rtl/core/atcc_pkg.sv =====
// atcc_pkg: shared constants, result type and colour helpers for the ansi text console
// cursor block. no dependencies; imported by every module of the block.
package atcc_pkg;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_TAB_STOP    = 8;

  localparam logic [6:0] ROW_COUNT_RESET    = 7'd25;
  localparam logic [7:0] COLUMN_COUNT_RESET = 8'd80;

  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  localparam logic [7:0] CHAR_BS     = 8'h08;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_ESC    = 8'h1B;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_LBRACK = 8'h5B;
  localparam logic [7:0] CHAR_SGR    = 8'h6D;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;

  localparam logic [7:0] SGR_RESET     = 8'd0;
  localparam logic [7:0] SGR_FORE_BASE = 8'd30;
  localparam logic [7:0] SGR_BACK_BASE = 8'd40;

  localparam logic [23:0] COLOUR_WHITE = 24'hFFFFFF;
  localparam logic [23:0] COLOUR_BLACK = 24'h000000;

  typedef struct packed {
    logic        row_clear;
    logic [5:0]  cleared_row;
    logic        cell_write;
    logic [5:0]  cell_row;
    logic [6:0]  cell_column;
    logic [7:0]  cell_char;
    logic [23:0] cell_fore;
    logic [23:0] cell_back;
  } res_t;

  typedef struct packed {
    logic [23:0] fore;
    logic [23:0] back;
  } colour_pair_t;

  typedef struct packed {
    logic norm_start;
    logic step_load;
  } ring_ctrl_t;

  function automatic logic [23:0] palette(logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd0:    c = 24'h000000;
      3'd1:    c = 24'hFF0000;
      3'd2:    c = 24'h00FF00;
      3'd3:    c = 24'hF08000;
      3'd4:    c = 24'h0000FF;
      3'd5:    c = 24'hFF00FF;
      3'd6:    c = 24'h008080;
      default: c = 24'h808080;
    endcase
    return c;
  endfunction

  function automatic colour_pair_t apply_sgr(logic [7:0] code, colour_pair_t cur);
    colour_pair_t r;
    logic [7:0]   off_f;
    logic [7:0]   off_b;
    r     = cur;
    off_f = code - SGR_FORE_BASE;
    off_b = code - SGR_BACK_BASE;
    if (code == SGR_RESET) begin
      r.fore = COLOUR_WHITE;
      r.back = COLOUR_BLACK;
    end else if (code >= SGR_FORE_BASE && code <= SGR_FORE_BASE + 8'd7) begin
      r.fore = palette(off_f[2:0]);
    end else if (code >= SGR_BACK_BASE && code <= SGR_BACK_BASE + 8'd7) begin
      r.back = palette(off_b[2:0]);
    end
    return r;
  endfunction

  function automatic logic [8:0] clamp_count(logic [8:0] v, int unsigned lim);
    logic [8:0] r;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (32'(v) > lim) begin
      r = 9'(lim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/atcc_ring_base.sv =====
// atcc_ring_base: raw and normalized top-row offset of the text ring buffer.
// reduces the offset modulo a newly written row count one quotient bit per cycle.
// depends on atcc_pkg.
module atcc_ring_base #(
  parameter int MAX_ROWS = atcc_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  atcc_pkg::ring_ctrl_t            ctrl_i,
  input  logic [$clog2(MAX_ROWS+1)-1:0]   rows_new_i,
  input  logic [$clog2(MAX_ROWS)-1:0]     top_new_i,
  output logic [$clog2(MAX_ROWS)-1:0]     base_o,
  output logic                            busy_o
);
  import atcc_pkg::*;

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int RIW = $clog2(MAX_ROWS);
  localparam int DW  = RCW + RIW;
  localparam int KW  = $clog2(RIW + 1);

  logic [RIW-1:0] top_q, top_d;
  logic [RIW-1:0] base_q, base_d;
  logic [DW-1:0]  div_q, div_d;
  logic [KW-1:0]  cnt_q, cnt_d;

  always_comb begin
    top_d  = top_q;
    base_d = base_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    if (ctrl_i.norm_start) begin
      base_d = top_q;
      div_d  = DW'(rows_new_i) << (RIW - 1);
      cnt_d  = KW'(RIW);
    end else if (cnt_q != '0) begin
      if (DW'(base_q) >= div_q) begin
        base_d = RIW'(DW'(base_q) - div_q);
      end
      div_d = div_q >> 1;
      cnt_d = cnt_q - KW'(1);
    end else if (ctrl_i.step_load) begin
      top_d  = top_new_i;
      base_d = top_new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      base_q <= '0;
      cnt_q  <= '0;
    end else begin
      top_q  <= top_d;
      base_q <= base_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
  end

  assign base_o = base_q;
  assign busy_o = (cnt_q != '0);

endmodule

// ===== rtl/core/atcc_out_buf.sv =====
// atcc_out_buf: output register with a skid entry for result items, so the input
// side keeps running while a result waits. depends on atcc_pkg.
module atcc_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  atcc_pkg::res_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output atcc_pkg::res_t out_data_o
);
  import atcc_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && !out_ready_i) begin
      if (in_valid_i) begin
        skid_d       = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else begin
      out_valid_d = in_valid_i;
      if (in_valid_i) begin
        out_d = in_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/core/ansi_text_console_cursor_top.sv =====
// ansi_text_console_cursor_top: cursor, ring offset, sgr colour parser and cell/row-clear
// result stream. depends on atcc_pkg, atcc_ring_base and atcc_out_buf.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/tready         tdata[7:0] char_in
//   m_axis    out  m_axis_tvalid/tready         tdata cell fields, tuser write/clear flags
//   cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i register, cfg_data_i value
//
// one character per cycle; each request is decoded in a single pass into the state
// registers and at most one result, held in an output register plus a skid entry.
// s_axis_tready drops only while the skid entry is full, and after a row_count write
// while the ring offset is reduced.
// reset: cursor home, offset 0, white on black, 25 rows by 80 columns.
module ansi_text_console_cursor_top #(
  parameter int MAX_ROWS    = atcc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = atcc_pkg::DEF_MAX_COLUMNS,
  parameter int TAB_STOP    = atcc_pkg::DEF_TAB_STOP
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // cell_row, cell_column, cell_char, cell_fore, cell_back, cleared_row, zero pad
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // cell_write, row_clear
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import atcc_pkg::*;

  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CCW = $clog2(MAX_COLUMNS + 1);
  localparam int CIW = $clog2(MAX_COLUMNS);
  localparam int TNW = CIW + 5;
  localparam int TPW = CIW + 17;
  // rounded-up reciprocal; exact quotient for columns below 256 and stops up to 16
  localparam int TAB_RECIP = (1 << 16) / TAB_STOP + 1;

  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_CSI  = 2'd2;

  logic [6:0]     row_count_q, row_count_d;
  logic [7:0]     column_count_q, column_count_d;
  logic [RIW-1:0] crow_q, crow_d;
  logic [CIW-1:0] ccol_q, ccol_d;
  logic [23:0]    fore_q, fore_d, back_q, back_d;
  logic [23:0]    pfore_q, pfore_d, pback_q, pback_d;
  logic [1:0]     phase_q, phase_d;
  logic [7:0]     param_q, param_d;

  logic           cfg_we;
  logic           accept;
  logic [7:0]     ch;
  logic [RCW-1:0] rows, rows_m1, rows_new;
  logic [CCW-1:0] cols, cols_m1;
  logic [RIW-1:0] cr, tb, tb_inc, phys, base_new;
  logic [CIW-1:0] cc;
  logic [RCW:0]   phys_sum;
  logic [TPW-1:0] tab_prod;
  logic [CIW-1:0] tab_quot;
  logic [TNW-1:0] tab_next;
  logic           tab_wrap;
  logic [CCW-1:0] pr_next;
  logic           pr_wrap;
  logic           last_row;
  logic [11:0]    digit_sum;
  colour_pair_t   sgr_new;
  logic           norm_busy;
  ring_ctrl_t     ring_ctrl;
  res_t           res;
  logic           res_valid;
  logic           buf_ready;
  res_t           out_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign ch          = s_axis_tdata;

  assign rows     = RCW'(clamp_count(9'(row_count_q), MAX_ROWS));
  assign cols     = CCW'(clamp_count(9'(column_count_q), MAX_COLUMNS));
  assign rows_new = RCW'(clamp_count(9'(cfg_data_i[6:0]), MAX_ROWS));
  assign rows_m1  = rows - RCW'(1);
  assign cols_m1  = cols - CCW'(1);

  assign cr = (RCW'(crow_q) > rows_m1) ? RIW'(rows_m1) : crow_q;
  assign cc = (CCW'(ccol_q) > cols_m1) ? CIW'(cols_m1) : ccol_q;

  assign phys_sum = (RCW+1)'(tb) + (RCW+1)'(cr);
  assign phys     = (phys_sum >= (RCW+1)'(rows)) ? RIW'(phys_sum - (RCW+1)'(rows))
                                                 : RIW'(phys_sum);
  assign tb_inc   = ((RCW'(tb) + RCW'(1)) == rows) ? '0 : tb + RIW'(1);
  assign last_row = (RCW'(cr) == rows_m1);

  assign tab_prod = TPW'(cc) * TPW'(TAB_RECIP);
  assign tab_quot = CIW'(tab_prod >> 16);
  assign tab_next = (TNW'(tab_quot) + TNW'(1)) * TNW'(TAB_STOP);
  assign tab_wrap = tab_next >= TNW'(cols);
  assign pr_next  = CCW'(cc) + CCW'(1);
  assign pr_wrap  = pr_next >= cols;

  assign digit_sum = 12'(param_q) * 12'd10 + 12'(ch - CHAR_ZERO);
  assign sgr_new   = apply_sgr(param_q, '{fore: pfore_q, back: pback_q});

  always_comb begin
    row_count_d    = row_count_q;
    column_count_d = column_count_q;
    if (cfg_we) begin
      case (cfg_index_i)
        REG_ROW_COUNT:    row_count_d    = cfg_data_i[6:0];
        REG_COLUMN_COUNT: column_count_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic row_inc;
    row_inc   = 1'b0;
    crow_d    = crow_q;
    ccol_d    = ccol_q;
    fore_d    = fore_q;
    back_d    = back_q;
    pfore_d   = pfore_q;
    pback_d   = pback_q;
    phase_d   = phase_q;
    param_d   = param_q;
    base_new  = tb;
    res       = '0;
    if (accept) begin
      crow_d = cr;
      ccol_d = cc;
      case (phase_q)
        PH_ESC: begin
          if (ch == CHAR_LBRACK) begin
            phase_d = PH_CSI;
            param_d = '0;
          end else begin
            phase_d = PH_TEXT;
          end
        end
        PH_CSI: begin
          if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            param_d = (digit_sum > 12'd255) ? 8'd255 : digit_sum[7:0];
          end else if (ch == CHAR_SEMI) begin
            pfore_d = sgr_new.fore;
            pback_d = sgr_new.back;
            param_d = '0;
          end else if (ch == CHAR_SGR) begin
            pfore_d = sgr_new.fore;
            pback_d = sgr_new.back;
            fore_d  = sgr_new.fore;
            back_d  = sgr_new.back;
            phase_d = PH_TEXT;
            param_d = '0;
          end else if (ch == CHAR_ESC) begin
            phase_d = PH_ESC;
            param_d = '0;
            pfore_d = fore_q;
            pback_d = back_q;
          end else if (ch >= FINAL_LO && ch <= FINAL_HI) begin
            phase_d = PH_TEXT;
            param_d = '0;
          end
        end
        default: begin
          phase_d = PH_TEXT;
          if (ch == CHAR_ESC) begin
            phase_d = PH_ESC;
            param_d = '0;
            pfore_d = fore_q;
            pback_d = back_q;
          end else if (ch == CHAR_BS) begin
            ccol_d          = (cc != '0) ? cc - CIW'(1) : cc;
            res.cell_write  = 1'b1;
            res.cell_row    = 6'(phys);
            res.cell_column = 7'(ccol_d);
            res.cell_char   = CHAR_SPACE;
            res.cell_fore   = fore_q;
            res.cell_back   = back_q;
          end else if (ch == CHAR_TAB) begin
            if (tab_wrap) begin
              ccol_d  = '0;
              row_inc = 1'b1;
            end else begin
              ccol_d = CIW'(tab_next);
            end
          end else if (ch == CHAR_LF) begin
            ccol_d  = '0;
            row_inc = 1'b1;
          end else if (ch == CHAR_CR) begin
            ccol_d = '0;
          end else begin
            res.cell_write  = 1'b1;
            res.cell_row    = 6'(phys);
            res.cell_column = 7'(cc);
            res.cell_char   = ch;
            res.cell_fore   = fore_q;
            res.cell_back   = back_q;
            if (pr_wrap) begin
              ccol_d  = '0;
              row_inc = 1'b1;
            end else begin
              ccol_d = CIW'(pr_next);
            end
          end
          if (row_inc) begin
            if (last_row) begin
              res.row_clear   = 1'b1;
              res.cleared_row = 6'(tb);
              base_new        = tb_inc;
            end else begin
              crow_d = cr + RIW'(1);
            end
          end
        end
      endcase
    end
  end

  assign res_valid = accept && (res.cell_write || res.row_clear);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= ROW_COUNT_RESET;
      column_count_q <= COLUMN_COUNT_RESET;
      crow_q         <= '0;
      ccol_q         <= '0;
      fore_q         <= COLOUR_WHITE;
      back_q         <= COLOUR_BLACK;
      pfore_q        <= COLOUR_WHITE;
      pback_q        <= COLOUR_BLACK;
      phase_q        <= PH_TEXT;
      param_q        <= '0;
    end else begin
      row_count_q    <= row_count_d;
      column_count_q <= column_count_d;
      crow_q         <= crow_d;
      ccol_q         <= ccol_d;
      fore_q         <= fore_d;
      back_q         <= back_d;
      pfore_q        <= pfore_d;
      pback_q        <= pback_d;
      phase_q        <= phase_d;
      param_q        <= param_d;
    end
  end

  assign ring_ctrl.norm_start = cfg_we && (cfg_index_i == REG_ROW_COUNT);
  assign ring_ctrl.step_load  = accept;

  atcc_ring_base #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ring_base (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ring_ctrl),
    .rows_new_i (rows_new),
    .top_new_i  (base_new),
    .base_o     (tb),
    .busy_o     (norm_busy)
  );

  assign s_axis_tready = !norm_busy && buf_ready;

  atcc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_ready_o  (buf_ready),
    .in_data_i   (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {5'd0, out_res.cleared_row, out_res.cell_back, out_res.cell_fore,
                         out_res.cell_char, out_res.cell_column, out_res.cell_row};
  assign m_axis_tuser = {out_res.row_clear, out_res.cell_write};

endmodule

// ===== dv/ansi_text_console_cursor_top_test.sv =====
// ansi_text_console_cursor_top_test: self-checking bench for the text console cursor block.
// queue-fed stream driver, random-stall result monitor and a per-character cursor/sgr tracker.
// depends on atcc_pkg and ansi_text_console_cursor_top.
`timescale 1ns / 1ps

module ansi_text_console_cursor_top_test;
  import atcc_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_CYCLES = 100;

  typedef enum logic [1:0] {
    PARSE_TEXT = 2'd0,
    PARSE_ESC  = 2'd1,
    PARSE_CSI  = 2'd2
  } parse_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = REG_ROW_COUNT;
  logic [7:0]  cfg_data_i = '0;

  ansi_text_console_cursor_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [7:0]  char_queue[$];
  res_t        expected_cells[$];
  int          queued_total = 0;
  int          chars_sent = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int          error_count = 0;
  int          quiet_cycles = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // tracked console state
  logic [6:0]  size_rows = ROW_COUNT_RESET;
  logic [7:0]  size_cols = COLUMN_COUNT_RESET;
  logic [5:0]  cur_row = '0;
  logic [6:0]  cur_col = '0;
  logic [5:0]  top_base = '0;
  logic [23:0] fore = COLOUR_WHITE;
  logic [23:0] back = COLOUR_BLACK;
  logic [23:0] pend_fore = COLOUR_WHITE;
  logic [23:0] pend_back = COLOUR_BLACK;
  parse_e      phase = PARSE_TEXT;
  logic [7:0]  param_acc = '0;

  function automatic logic [23:0] colour_of(input int idx);
    case (idx)
      0:       return 24'h000000;
      1:       return 24'hFF0000;
      2:       return 24'h00FF00;
      3:       return 24'hF08000;
      4:       return 24'h0000FF;
      5:       return 24'hFF00FF;
      6:       return 24'h008080;
      default: return 24'h808080;
    endcase
  endfunction

  task automatic apply_colour_code(input int code);
    if (code == int'(SGR_RESET)) begin
      pend_fore = COLOUR_WHITE;
      pend_back = COLOUR_BLACK;
    end else if (code >= int'(SGR_FORE_BASE) && code <= int'(SGR_FORE_BASE) + 7) begin
      pend_fore = colour_of(code - int'(SGR_FORE_BASE));
    end else if (code >= int'(SGR_BACK_BASE) && code <= int'(SGR_BACK_BASE) + 7) begin
      pend_back = colour_of(code - int'(SGR_BACK_BASE));
    end
  endtask

  task automatic track_char(input logic [7:0] c);
    int   rows;
    int   cols;
    int   row;
    int   col;
    int   base;
    int   acc;
    logic wr;
    logic clr;
    res_t exp_item;
    rows = (size_rows == 0) ? 1 : ((int'(size_rows) > DEF_MAX_ROWS) ? DEF_MAX_ROWS
                                                                    : int'(size_rows));
    cols = (size_cols == 0) ? 1 : ((int'(size_cols) > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS
                                                                       : int'(size_cols));
    row = (int'(cur_row) >= rows) ? rows - 1 : int'(cur_row);
    col = (int'(cur_col) >= cols) ? cols - 1 : int'(cur_col);
    base = int'(top_base) % rows;
    exp_item = '0;
    wr = 1'b0;
    clr = 1'b0;
    case (phase)
      PARSE_ESC: begin
        if (c == CHAR_LBRACK) begin
          phase = PARSE_CSI;
          param_acc = '0;
        end else begin
          phase = PARSE_TEXT;
        end
      end
      PARSE_CSI: begin
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
          acc = int'(param_acc) * 10 + int'(c - CHAR_ZERO);
          param_acc = (acc > 255) ? 8'd255 : 8'(acc);
        end else if (c == CHAR_SEMI) begin
          apply_colour_code(int'(param_acc));
          param_acc = '0;
        end else if (c == CHAR_SGR) begin
          apply_colour_code(int'(param_acc));
          fore = pend_fore;
          back = pend_back;
          phase = PARSE_TEXT;
          param_acc = '0;
        end else if (c == CHAR_ESC) begin
          phase = PARSE_ESC;
          param_acc = '0;
          pend_fore = fore;
          pend_back = back;
        end else if (c >= FINAL_LO && c <= FINAL_HI) begin
          phase = PARSE_TEXT;
          param_acc = '0;
        end
      end
      default: begin
        phase = PARSE_TEXT;
        if (c == CHAR_ESC) begin
          phase = PARSE_ESC;
          param_acc = '0;
          pend_fore = fore;
          pend_back = back;
        end else if (c == CHAR_BS) begin
          if (col != 0) col--;
          wr = 1'b1;
          exp_item.cell_row = 6'((base + row) % rows);
          exp_item.cell_column = 7'(col);
          exp_item.cell_char = CHAR_SPACE;
        end else if (c == CHAR_TAB) begin
          col = (col / DEF_TAB_STOP + 1) * DEF_TAB_STOP;
          if (col >= cols) begin
            col = 0;
            row++;
          end
        end else if (c == CHAR_LF) begin
          col = 0;
          row++;
        end else if (c == CHAR_CR) begin
          col = 0;
        end else begin
          wr = 1'b1;
          exp_item.cell_row = 6'((base + row) % rows);
          exp_item.cell_column = 7'(col);
          exp_item.cell_char = c;
          col++;
          if (col >= cols) begin
            col = 0;
            row++;
          end
        end
        // scroll: advance the ring and blank the new bottom row
        if (row >= rows) begin
          clr = 1'b1;
          exp_item.cleared_row = 6'(base);
          base = (base + 1) % rows;
          row = rows - 1;
        end
      end
    endcase
    cur_row = 6'(row);
    cur_col = 7'(col);
    top_base = 6'(base);
    if (wr) begin
      exp_item.cell_write = 1'b1;
      exp_item.cell_fore = fore;
      exp_item.cell_back = back;
    end
    exp_item.row_clear = clr;
    if (wr || clr) expected_cells.push_back(exp_item);
  endtask

  function automatic string cell_text(input res_t r);
    return $sformatf("wr=%0d row=%0d col=%0d chr=%h fg=%h bg=%h clr=%0d crow=%0d",
                     r.cell_write, r.cell_row, r.cell_column, r.cell_char,
                     r.cell_fore, r.cell_back, r.row_clear, r.cleared_row);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_char(s_axis_tdata);
        chars_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (char_queue.size() != 0 &&
            !((chars_sent < 250 || chars_sent > 350) && $urandom_range(99) < 26)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= char_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '0;
        got.cell_write = m_axis_tuser[0];
        got.row_clear = m_axis_tuser[1];
        got.cell_row = m_axis_tdata[5:0];
        got.cell_column = m_axis_tdata[12:6];
        got.cell_char = m_axis_tdata[20:13];
        got.cell_fore = m_axis_tdata[44:21];
        got.cell_back = m_axis_tdata[68:45];
        got.cleared_row = m_axis_tdata[74:69];
        results_seen++;
        if (expected_cells.size() == 0) begin
          if (error_count < 10) $display("unexpected result: %s", cell_text(got));
          error_count++;
        end else begin
          want = expected_cells.pop_front();
          if (got.cell_write !== want.cell_write || got.cell_row !== want.cell_row ||
              got.cell_column !== want.cell_column || got.cell_char !== want.cell_char ||
              got.cell_fore !== want.cell_fore || got.cell_back !== want.cell_back ||
              got.row_clear !== want.row_clear || got.cleared_row !== want.cleared_row) begin
            if (error_count < 10) begin
              $display("mismatch at result %0d", results_seen);
              $display("  expected %s", cell_text(want));
              $display("  actual   %s", cell_text(got));
            end
            error_count++;
          end
        end
      end
      // one long back-pressure window while the sender keeps offering
      if (!hold_done && results_seen >= 120 && s_axis_tvalid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (results_seen >= 250 && results_seen <= 330) ||
                         ($urandom_range(99) >= 26);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic put_char(input logic [7:0] c);
    char_queue.push_back(c);
    queued_total++;
  endtask

  task automatic put_number(input int v);
    if (v >= 100) put_char(CHAR_ZERO + 8'(v / 100));
    if (v >= 10) put_char(CHAR_ZERO + 8'((v / 10) % 10));
    put_char(CHAR_ZERO + 8'(v % 10));
  endtask

  task automatic queue_random(input int n);
    int goal;
    int pick;
    int nparams;
    goal = queued_total + n;
    while (queued_total < goal) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        put_char(8'($urandom_range(8'h7E, 8'h20)));
      end else if (pick < 55) begin
        case ($urandom_range(3))
          0:       put_char(CHAR_BS);
          1:       put_char(CHAR_TAB);
          2:       put_char(CHAR_LF);
          default: put_char(CHAR_CR);
        endcase
      end else if (pick < 80) begin
        put_char(CHAR_ESC);
        put_char(CHAR_LBRACK);
        nparams = $urandom_range(3, 1);
        for (int i = 0; i < nparams; i++) begin
          if (i != 0) put_char(CHAR_SEMI);
          case ($urandom_range(5))
            0:       put_number(int'(SGR_RESET));
            1, 2:    put_number(int'(SGR_FORE_BASE) + $urandom_range(7));
            3:       put_number(int'(SGR_BACK_BASE) + $urandom_range(7));
            4:       put_number($urandom_range(999));
            default: ;
          endcase
        end
        if ($urandom_range(99) < 85) put_char(CHAR_SGR);
        else put_char(8'($urandom_range(FINAL_HI, FINAL_LO)));
      end else if (pick < 90) begin
        put_char(8'($urandom_range(255)));
      end else begin
        put_char(CHAR_ESC);
        if ($urandom_range(1) == 1) begin
          put_char(CHAR_LBRACK);
          put_number($urandom_range(50));
          put_char(CHAR_SEMI);
          put_char(CHAR_ESC);
        end else begin
          put_char(8'($urandom_range(255)));
        end
      end
    end
  endtask

  task automatic wait_drained();
    while (char_queue.size() != 0 || s_axis_tvalid || expected_cells.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_ROW_COUNT) size_rows = value[6:0];
    else size_cols = value;
    reg_writes++;
  endtask

  task automatic size_phase(input logic [7:0] rows, input logic [7:0] cols, input int n);
    wait_drained();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
    queue_random(n);
  endtask

  initial begin
    int drain;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: byte extremes, backspace at column zero, tab, controls, sgr, dropped escape
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CHAR_CR);
    put_char(CHAR_BS);
    put_char(CHAR_TAB);
    put_char(CHAR_BS);
    put_char(CHAR_LF);
    put_char(CHAR_ESC);
    put_char(CHAR_LBRACK);
    put_number(31);
    put_char(CHAR_SEMI);
    put_number(42);
    put_char(CHAR_SGR);
    put_char(8'h7F);
    put_char(CHAR_ESC);
    put_char(8'h78);
    put_char(CHAR_ESC);
    put_char(CHAR_LBRACK);
    put_number(999);
    put_char(8'h48);
    put_char(CHAR_ESC);
    put_char(CHAR_LBRACK);
    put_char(CHAR_SGR);
    put_char(8'h5A);

    size_phase(8'd3, 8'd10, 100);
    size_phase(8'd1, 8'd1, 40);
    size_phase(8'd64, 8'd128, 60);
    size_phase(8'd0, 8'd0, 30);
    size_phase(8'hFF, 8'hFF, 40);
    size_phase(8'd2, 8'd9, 100);
    size_phase(8'd5, 8'd17, 100);
    size_phase(8'd4, 8'd3, 60);

    drain = 0;
    while ((char_queue.size() != 0 || s_axis_tvalid || expected_cells.size() != 0) &&
           drain < DRAIN_LIMIT) begin
      @(negedge clk_i);
      drain++;
    end
    if (expected_cells.size() != 0) begin
      $display("%0d expected results never arrived", expected_cells.size());
      error_count += expected_cells.size();
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("sent %0d characters through 9 console sizes with %0d register writes,",
             chars_sent, reg_writes);
    $display("checked %0d cell and row-clear results, %0d errors", results_seen, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== ansi_text_console_cursor_top.f =====
rtl/core/atcc_pkg.sv
rtl/core/atcc_ring_base.sv
rtl/core/atcc_out_buf.sv
rtl/core/ansi_text_console_cursor_top.sv
dv/ansi_text_console_cursor_top_test.sv
